// ===== sv/sgw_pkg.sv =====
// Package of the servo gait wave generator: operation and divider codes,
// fixed-point constants and the command and status structs of the core.
// No dependencies.
package sgw_pkg;

  localparam int JOINTS = 3;
  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int CFG_IW = 3;
  localparam int CFG_TRIM_BASE = 0;
  localparam int CFG_LAG_BASE = JOINTS;

  localparam logic [7:0] TRIM_RESET = 8'd60;
  localparam logic [7:0] LAG_RESET [8] = '{8'd0, 8'd80, 8'd120, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  localparam int DIV_W = 24;
  localparam int DEN_W = 16;

  localparam logic [15:0] Q13_HALF_PI = 16'd12868;
  localparam logic [15:0] Q13_PI = 16'd25736;
  localparam logic [15:0] Q13_THREE_HALF_PI = 16'd38604;
  localparam logic [15:0] Q13_TWO_PI = 16'd51472;
  // Lag angle is lag * 25736 / 180, taken as a multiply by 2^16 * 6434 / 45 rounded up.
  localparam logic [23:0] LAG_RECIP = 24'd9370192;
  localparam logic [16:0] DIV3_RECIP = 17'd43691;

  localparam int PULSE_MID = 1500;
  localparam int TRIM_BIAS = 300;
  localparam logic signed [15:0] PULSE_BASE = 16'(PULSE_MID - TRIM_BIAS);
  localparam logic signed [15:0] PULSE_MIN = 16'sd600;
  localparam logic signed [15:0] PULSE_MAX = 16'sd2400;
  localparam logic [3:0] DIR_STRAIGHT = 4'd7;
  localparam logic [3:0] DIR_LIMIT = 4'd14;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PERIOD = 2'd1,
    OP_AMP    = 2'd2,
    OP_TURN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIV_PHASE = 2'd0,
    DIV_ANGLE = 2'd1
  } div_sel_e;

  typedef struct packed {
    logic     tick_load;
    logic     wr_en;
    logic     div_start;
    div_sel_e div_sel;
    logic     phase_load;
    logic     r_load;
    logic     l_load;
    logic     fold;
    logic     sq;
    logic     cube;
    logic     sine;
    logic     term;
    logic     pulse;
    logic     joint_next;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_joint;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/sgw_ram.sv =====
// Generic single-port-write RAM with a registered read port.
// No dependencies.
module sgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sgw_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on sgw_pkg for the operand widths.
module sgw_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sgw_pkg::DIV_W-1:0]  dividend_i,
  input  logic [sgw_pkg::DEN_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [sgw_pkg::DIV_W-1:0]  quotient_o,
  output logic [sgw_pkg::DEN_W-1:0]  remainder_o
);

  localparam int CW = $clog2(sgw_pkg::DIV_W);

  logic [sgw_pkg::DIV_W-1:0] quo_q;
  logic [sgw_pkg::DEN_W-1:0] rem_q, rem_d, den_q;
  logic [CW-1:0]             cnt_q;
  logic                      busy_q, done_q;
  logic [sgw_pkg::DEN_W:0]   shifted, diff;
  logic                      ge;

  always_comb begin
    shifted = {rem_q, quo_q[sgw_pkg::DIV_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? diff[sgw_pkg::DEN_W-1:0] : shifted[sgw_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(sgw_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[sgw_pkg::DIV_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a division");
  a_busy_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= CW'(sgw_pkg::DIV_W - 1)) else $error("divider count overrun");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider still busy at done");

endmodule

// ===== sv/sgw_datapath.sv =====
// Datapath of the gait generator: tables, trim and lag registers, phase
// counter, shared divider, sine and pulse arithmetic and the result register.
// Depends on sgw_pkg, sgw_ram and sgw_div.
module sgw_datapath #(
  parameter int SPEED_LEVELS = 16,
  parameter int TURN_ROWS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sgw_pkg::dp_cmd_t           cmd_i,
  output sgw_pkg::dp_status_t        status_o,
  input  logic [1:0]                 op_i,
  input  logic [3:0]                 speed_level_i,
  input  logic [3:0]                 direction_i,
  input  logic [5:0]                 table_index_i,
  input  logic [7:0]                 table_value_i,
  input  logic                       cfg_we_i,
  input  logic [sgw_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [7:0]                 cfg_data_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [11:0]                pulse_joint0_o,
  output logic [11:0]                pulse_joint1_o,
  output logic [11:0]                pulse_joint2_o,
  output logic [7:0]                 phase_now_o
);

  localparam int J = sgw_pkg::JOINTS;
  localparam int SW = (SPEED_LEVELS > 1) ? $clog2(SPEED_LEVELS) : 1;
  localparam int AMP_DEPTH = SPEED_LEVELS * J;
  localparam int AW = $clog2(AMP_DEPTH);
  localparam int TURN_DEPTH = TURN_ROWS * J;
  localparam int TW = $clog2(TURN_DEPTH);

  logic [7:0] trim_q [J];
  logic [7:0] lag_q [J];
  logic [7:0] period_q [SPEED_LEVELS];
  logic [7:0] turn_q [TURN_DEPTH];
  logic [AMP_DEPTH-1:0] amp_vld_q;
  logic                 amp_rv_q;
  logic [7:0]           amp_rdata;

  logic [7:0]  phase_q, per_q;
  logic [3:0]  sel_q, row_q, sel_d, row_d, dir_lim;
  logic        lvl_zero_q, dir_sub_q, neg_q;
  logic [sgw_pkg::JW-1:0] j_q;
  logic [15:0] r0_q, l_q;
  logic [13:0] t_q;
  logic [27:0] sq_q;
  logic [41:0] cube_q;
  logic [14:0] y_q;
  logic [26:0] term_q;
  logic [11:0] pulse_q [J];
  logic        out_valid_q;
  logic [11:0] out_pulse_q [J];
  logic [7:0]  out_phase_q;

  logic        div_done;
  logic [23:0] div_quo, div_dividend;
  logic [15:0] div_rem, div_divisor;
  logic [7:0]  ph2, lag_sel, trim_sel, amp;
  logic [31:0] lag_prod;
  logic [5:0]  amp_addr_w, turn_addr_w;
  logic [16:0] fdiff;
  logic [15:0] x, div3;
  logic [13:0] t_d;
  logic        neg_d;
  logic [32:0] c3_prod;
  logic [15:0] y_d;
  logic [11:0] amp10;
  logic signed [15:0] base, turn10, mag, p, p_sat;
  logic [7:0]  turn_rd;
  logic        amp_we;

  assign ph2      = phase_q + 8'd2;
  assign lag_sel  = lag_q[j_q];
  assign trim_sel = trim_q[j_q];
  assign lag_prod = 32'(lag_sel) * 32'(sgw_pkg::LAG_RECIP);

  // The phase is always below a nonzero period, so the angle quotient is
  // already below 2pi and needs no wrap.
  always_comb begin
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd_i.div_sel)
      sgw_pkg::DIV_PHASE: begin
        div_dividend = {16'd0, ph2};
        div_divisor  = {8'd0, per_q};
      end
      sgw_pkg::DIV_ANGLE: begin
        div_dividend = 24'(phase_q) * 24'(sgw_pkg::Q13_TWO_PI);
        div_divisor  = {8'd0, per_q};
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  sgw_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign amp_we = cmd_i.wr_en && (op_i == sgw_pkg::OP_AMP) && (32'(table_index_i) < AMP_DEPTH);
  assign amp_addr_w = 6'(sel_q) * 6'(J) + 6'(j_q);

  sgw_ram #(
    .WIDTH (8),
    .DEPTH (AMP_DEPTH)
  ) u_amp_ram (
    .clk_i   (clk_i),
    .we_i    (amp_we),
    .waddr_i (table_index_i[AW-1:0]),
    .wdata_i (table_value_i),
    .raddr_i (amp_addr_w[AW-1:0]),
    .rdata_o (amp_rdata)
  );

  assign amp = amp_rv_q ? amp_rdata : 8'd0;
  assign turn_addr_w = 6'(row_q) * 6'(J) + 6'(j_q);
  assign turn_rd = turn_q[turn_addr_w[TW-1:0]];

  always_comb begin
    sel_d = (speed_level_i > 4'(SPEED_LEVELS - 1)) ? 4'(SPEED_LEVELS - 1) : speed_level_i;
    dir_lim = (direction_i > sgw_pkg::DIR_LIMIT) ? sgw_pkg::DIR_LIMIT : direction_i;
    row_d = (direction_i >= sgw_pkg::DIR_STRAIGHT) ? sgw_pkg::DIR_LIMIT - dir_lim : direction_i;
    if (row_d > 4'(TURN_ROWS - 1)) begin
      row_d = 4'(TURN_ROWS - 1);
    end
  end

  always_comb begin
    fdiff = {1'b0, r0_q} - {1'b0, l_q};
    x = fdiff[16] ? fdiff[15:0] + sgw_pkg::Q13_TWO_PI : fdiff[15:0];
    if (x <= sgw_pkg::Q13_HALF_PI) begin
      t_d = x[13:0];
      neg_d = 1'b0;
    end else if (x <= sgw_pkg::Q13_PI) begin
      t_d = 14'(sgw_pkg::Q13_PI - x);
      neg_d = 1'b0;
    end else if (x <= sgw_pkg::Q13_THREE_HALF_PI) begin
      t_d = 14'(x - sgw_pkg::Q13_PI);
      neg_d = 1'b1;
    end else begin
      t_d = 14'(sgw_pkg::Q13_TWO_PI - x);
      neg_d = 1'b1;
    end
  end

  always_comb begin
    c3_prod = 33'(cube_q[41:26]) * 33'(sgw_pkg::DIV3_RECIP);
    div3 = c3_prod[32:17];
    y_d = {1'b0, t_q, 1'b0} - div3;
    amp10 = {1'b0, amp, 3'd0} + {3'd0, amp, 1'b0};
  end

  always_comb begin
    base = sgw_pkg::PULSE_BASE + 16'({trim_sel, 2'b00}) + 16'(trim_sel);
    turn10 = 16'({turn_rd, 3'b000}) + 16'({turn_rd, 1'b0});
    mag = 16'(term_q[26:14]);
    if (lvl_zero_q) begin
      p = base;
    end else begin
      p = base + (dir_sub_q ? -turn10 : turn10) + (neg_q ? -mag : mag) - 16'sd1;
    end
    if (p < sgw_pkg::PULSE_MIN) begin
      p_sat = sgw_pkg::PULSE_MIN;
    end else if (p > sgw_pkg::PULSE_MAX) begin
      p_sat = sgw_pkg::PULSE_MAX;
    end else begin
      p_sat = p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < J; k++) begin
        trim_q[k] <= sgw_pkg::TRIM_RESET;
        lag_q[k]  <= sgw_pkg::LAG_RESET[k % 8];
      end
      for (int k = 0; k < SPEED_LEVELS; k++) begin
        period_q[k] <= '0;
      end
      for (int k = 0; k < TURN_DEPTH; k++) begin
        turn_q[k] <= '0;
      end
      amp_vld_q   <= '0;
      amp_rv_q    <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      j_q         <= '0;
    end else begin
      amp_rv_q <= amp_vld_q[amp_addr_w[AW-1:0]];
      for (int k = 0; k < J; k++) begin
        if (cfg_we_i && cfg_index_i == sgw_pkg::CFG_IW'(sgw_pkg::CFG_TRIM_BASE + k)) begin
          trim_q[k] <= cfg_data_i;
        end
        if (cfg_we_i && cfg_index_i == sgw_pkg::CFG_IW'(sgw_pkg::CFG_LAG_BASE + k)) begin
          lag_q[k] <= cfg_data_i;
        end
      end
      if (cmd_i.wr_en) begin
        unique case (sgw_pkg::op_e'(op_i))
          sgw_pkg::OP_PERIOD: begin
            if (32'(table_index_i) < SPEED_LEVELS) begin
              period_q[table_index_i[SW-1:0]] <= table_value_i;
            end
          end
          sgw_pkg::OP_AMP: begin
            if (amp_we) begin
              amp_vld_q[table_index_i[AW-1:0]] <= 1'b1;
            end
          end
          sgw_pkg::OP_TURN: begin
            if (32'(table_index_i) < TURN_DEPTH) begin
              turn_q[table_index_i[TW-1:0]] <= table_value_i;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.tick_load) begin
        j_q <= '0;
      end else if (cmd_i.joint_next) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.phase_load && per_q != 8'd0) begin
        phase_q <= div_rem[7:0];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_load) begin
      sel_q      <= sel_d;
      row_q      <= row_d;
      per_q      <= period_q[sel_d[SW-1:0]];
      lvl_zero_q <= speed_level_i == 4'd0;
      dir_sub_q  <= direction_i >= sgw_pkg::DIR_STRAIGHT;
    end
    if (cmd_i.r_load) begin
      r0_q <= div_quo[15:0];
    end
    if (cmd_i.l_load) begin
      l_q <= lag_prod[31:16];
    end
    if (cmd_i.fold) begin
      t_q   <= t_d;
      neg_q <= neg_d;
    end
    if (cmd_i.sq) begin
      sq_q <= 28'(t_q) * 28'(t_q);
    end
    if (cmd_i.cube) begin
      cube_q <= 42'(sq_q) * 42'(t_q);
    end
    if (cmd_i.sine) begin
      y_q <= (per_q == 8'd0) ? 15'd0 : y_d[14:0];
    end
    if (cmd_i.term) begin
      term_q <= 27'(amp10) * 27'(y_q);
    end
    if (cmd_i.pulse) begin
      pulse_q[j_q] <= p_sat[11:0];
    end
    if (cmd_i.out_load) begin
      for (int k = 0; k < J; k++) begin
        out_pulse_q[k] <= pulse_q[k];
      end
      out_phase_q <= phase_q;
    end
  end

  assign status_o.div_done   = div_done;
  assign status_o.last_joint = j_q == sgw_pkg::JW'(J - 1);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign pulse_joint0_o = out_pulse_q[0];
  assign pulse_joint1_o = out_pulse_q[1];
  assign pulse_joint2_o = out_pulse_q[2];
  assign phase_now_o    = out_phase_q;

endmodule

// ===== sv/sgw_ctrl.sv =====
// Controller of the gait generator: sequences the divisions, the sine steps
// and the per-joint pulse loop. Depends on sgw_pkg.
module sgw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          op_i,
  output logic                in_stall_o,
  input  sgw_pkg::dp_status_t status_i,
  output sgw_pkg::dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PH    = 4'd1;
  localparam logic [3:0] S_PH_W  = 4'd2;
  localparam logic [3:0] S_AN    = 4'd3;
  localparam logic [3:0] S_AN_W  = 4'd4;
  localparam logic [3:0] S_LG    = 4'd7;
  localparam logic [3:0] S_FOLD  = 4'd9;
  localparam logic [3:0] S_SQ    = 4'd10;
  localparam logic [3:0] S_CUBE  = 4'd11;
  localparam logic [3:0] S_SINE  = 4'd12;
  localparam logic [3:0] S_TERM  = 4'd13;
  localparam logic [3:0] S_PULSE = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = state_q != S_IDLE;
  assign accept = in_valid_i && state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.div_sel = sgw_pkg::DIV_PHASE;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_i == sgw_pkg::OP_TICK) begin
            cmd_o.tick_load = 1'b1;
            state_d = S_PH;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_PH: begin
        cmd_o.div_start = 1'b1;
        state_d = S_PH_W;
      end
      S_PH_W: begin
        if (status_i.div_done) begin
          cmd_o.phase_load = 1'b1;
          state_d = S_AN;
        end
      end
      S_AN: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = sgw_pkg::DIV_ANGLE;
        state_d = S_AN_W;
      end
      S_AN_W: begin
        cmd_o.div_sel = sgw_pkg::DIV_ANGLE;
        if (status_i.div_done) begin
          cmd_o.r_load = 1'b1;
          state_d = S_LG;
        end
      end
      S_LG: begin
        cmd_o.l_load = 1'b1;
        state_d = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d = S_CUBE;
      end
      S_CUBE: begin
        cmd_o.cube = 1'b1;
        state_d = S_SINE;
      end
      S_SINE: begin
        cmd_o.sine = 1'b1;
        state_d = S_TERM;
      end
      S_TERM: begin
        cmd_o.term = 1'b1;
        state_d = S_PULSE;
      end
      S_PULSE: begin
        cmd_o.pulse = 1'b1;
        if (status_i.last_joint) begin
          state_d = S_OUT;
        end else begin
          cmd_o.joint_next = 1'b1;
          state_d = S_LG;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_out_after_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> $past(state_q) == S_PULSE || $past(state_q) == S_OUT)
    else $error("result loaded without finished joints");
  a_tick_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick_load |=> cmd_o.div_start) else $error("tick did not start division");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> !in_stall_o) else $error("table write while busy");

endmodule

// ===== sv/servo_gait_wave_generator.sv =====
// Servo gait wave generator, top level: joins the controller and the datapath.
// Depends on sgw_pkg, sgw_ctrl and sgw_datapath.
//
// A tick runs from its acceptance through two divisions on the one shared
// radix-2 divider, for the new phase and the angle, then through the lag, sine
// and pulse arithmetic of each joint in turn, and ends with the load of the
// result register, which waits while the previous result is stalled. A table
// write is done when it is accepted. The block takes one request at a time; a
// finished result waits in the output register while the next request is taken.
module servo_gait_wave_generator #(
  parameter int SPEED_LEVELS = 16,
  parameter int TURN_ROWS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [3:0]                 speed_level_i,
  input  logic [3:0]                 direction_i,
  input  logic [5:0]                 table_index_i,
  input  logic [7:0]                 table_value_i,
  input  logic                       cfg_we_i,
  input  logic [sgw_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [7:0]                 cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [11:0]                pulse_joint0_o,
  output logic [11:0]                pulse_joint1_o,
  output logic [11:0]                pulse_joint2_o,
  output logic [7:0]                 phase_now_o
);

  sgw_pkg::dp_cmd_t    cmd;
  sgw_pkg::dp_status_t status;

  sgw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sgw_datapath #(
    .SPEED_LEVELS (SPEED_LEVELS),
    .TURN_ROWS    (TURN_ROWS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (op_i),
    .speed_level_i  (speed_level_i),
    .direction_i    (direction_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pulse_joint0_o (pulse_joint0_o),
    .pulse_joint1_o (pulse_joint1_o),
    .pulse_joint2_o (pulse_joint2_o),
    .phase_now_o    (phase_now_o)
  );

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pulse_joint0_o >= 12'd600 && pulse_joint0_o <= 12'd2400
      && pulse_joint1_o >= 12'd600 && pulse_joint1_o <= 12'd2400
      && pulse_joint2_o >= 12'd600 && pulse_joint2_o <= 12'd2400)
    else $error("pulse width out of range");
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i == sgw_pkg::OP_TICK |=> in_stall_o)
    else $error("tick request not worked on");
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)) else $error("result without a tick");

endmodule

// ===== tb/servo_gait_wave_generator_test.sv =====
// Testbench of the servo gait wave generator: drives table writes, register
// writes and ticks, predicts each tick's pulse widths and phase in place and
// checks every result. Depends on sgw_pkg and servo_gait_wave_generator.
`timescale 1ns / 100ps

module servo_gait_wave_generator_test;

  typedef struct {
    sgw_pkg::op_e op;
    logic [3:0]   level;
    logic [3:0]   dir;
    logic [5:0]   idx;
    logic [7:0]   val;
  } request_t;

  typedef struct {
    logic [11:0] pulse [3];
    logic [7:0]  phase;
  } pose_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic [1:0] op = sgw_pkg::OP_TICK;
  logic [3:0] speed_level = '0;
  logic [3:0] direction = '0;
  logic [5:0] table_index = '0;
  logic [7:0] table_value = '0;
  logic cfg_we = 1'b0;
  logic [sgw_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic [11:0] pulse_joint0_o, pulse_joint1_o, pulse_joint2_o;
  logic [7:0] phase_now_o;

  request_t request_q [$];
  pose_t pending_poses [$];
  request_t cur_request;
  bit no_idle = 0;
  bit failed = 0;
  int quiet_cycles = 0;

  logic [7:0] phase_ctr;
  logic [7:0] period_tab [16];
  logic [7:0] amp_tab [48];
  logic [7:0] turn_tab [24];
  logic [7:0] trim [3];
  logic [7:0] lag [3];

  always #5 clk_i = ~clk_i;

  servo_gait_wave_generator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .op_i(op), .speed_level_i(speed_level), .direction_i(direction),
    .table_index_i(table_index), .table_value_i(table_value),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .pulse_joint0_o(pulse_joint0_o), .pulse_joint1_o(pulse_joint1_o),
    .pulse_joint2_o(pulse_joint2_o), .phase_now_o(phase_now_o)
  );

  function automatic longint sine_q14(logic [7:0] ph, logic [7:0] per, logic [7:0] lg);
    longint x, t, cube, y, two_pi, pi, half_pi, three_half_pi;
    bit neg;
    neg = 0;
    two_pi = longint'(sgw_pkg::Q13_TWO_PI);
    pi = longint'(sgw_pkg::Q13_PI);
    half_pi = longint'(sgw_pkg::Q13_HALF_PI);
    three_half_pi = longint'(sgw_pkg::Q13_THREE_HALF_PI);
    if (per == 0) return 0;
    x = (two_pi * longint'(ph)) / longint'(per) - (pi * longint'(lg)) / 180;
    x = x % two_pi;
    if (x < 0) x += two_pi;
    if (x <= half_pi) begin
      t = x;
    end else if (x <= pi) begin
      t = pi - x;
    end else if (x <= three_half_pi) begin
      t = x - pi;
      neg = 1;
    end else begin
      t = two_pi - x;
      neg = 1;
    end
    cube = t * t * t;
    y = 2 * t - cube / (longint'(3) << 26);
    return neg ? -y : y;
  endfunction

  function automatic void predict_gait(request_t r);
    pose_t pose;
    logic [7:0] per;
    int row, p, turn, term;
    longint y, ymag;
    case (r.op)
      sgw_pkg::OP_PERIOD: if (r.idx < 16) period_tab[r.idx] = r.val;
      sgw_pkg::OP_AMP:    if (r.idx < 48) amp_tab[r.idx] = r.val;
      sgw_pkg::OP_TURN:   if (r.idx < 24) turn_tab[r.idx] = r.val;
      default: begin
        per = period_tab[r.level];
        if (per != 0) phase_ctr = 8'((phase_ctr + 8'd2)) % per;
        if (r.dir >= sgw_pkg::DIR_STRAIGHT) begin
          row = sgw_pkg::DIR_LIMIT
              - ((r.dir > sgw_pkg::DIR_LIMIT) ? sgw_pkg::DIR_LIMIT : r.dir);
        end else begin
          row = r.dir;
        end
        if (row > 7) row = 7;
        for (int j = 0; j < 3; j++) begin
          p = sgw_pkg::PULSE_MID + 5 * trim[j] - sgw_pkg::TRIM_BIAS;
          if (r.level != 0) begin
            turn = 10 * turn_tab[row * 3 + j];
            y = sine_q14(phase_ctr, per, lag[j]);
            ymag = (y < 0) ? -y : y;
            term = int'((longint'(amp_tab[r.level * 3 + j]) * 10 * ymag) >>> 14);
            if (y < 0) term = -term;
            p += (r.dir >= sgw_pkg::DIR_STRAIGHT) ? -turn : turn;
            p += term - 1;
          end
          if (p < 600) p = 600;
          if (p > 2400) p = 2400;
          pose.pulse[j] = 12'(p);
        end
        pose.phase = phase_ctr;
        pending_poses.push_back(pose);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) predict_gait(cur_request);
      if (!in_valid || !in_stall_o) begin
        if (request_q.size() > 0 && (no_idle || $urandom_range(99) >= 21)) begin
          nxt = request_q.pop_front();
          cur_request = nxt;
          op <= nxt.op;
          speed_level <= nxt.level;
          direction <= nxt.dir;
          table_index <= nxt.idx;
          table_value <= nxt.val;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 21);
      if (out_valid_o && !out_stall) begin
        if (pending_poses.size() == 0) begin
          $error("result with no expectation waiting");
          failed = 1;
        end else begin
          want = pending_poses.pop_front();
          if (pulse_joint0_o !== want.pulse[0]) begin
            $error("pulse_joint0 expected %0d actual %0d", want.pulse[0], pulse_joint0_o);
            failed = 1;
          end
          if (pulse_joint1_o !== want.pulse[1]) begin
            $error("pulse_joint1 expected %0d actual %0d", want.pulse[1], pulse_joint1_o);
            failed = 1;
          end
          if (pulse_joint2_o !== want.pulse[2]) begin
            $error("pulse_joint2 expected %0d actual %0d", want.pulse[2], pulse_joint2_o);
            failed = 1;
          end
          if (phase_now_o !== want.phase) begin
            $error("phase_now expected %0d actual %0d", want.phase, phase_now_o);
            failed = 1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_request(sgw_pkg::op_e o, int lvl, int d, int i, int v);
    request_t r;
    r.op = o;
    r.level = 4'(lvl);
    r.dir = 4'(d);
    r.idx = 6'(i);
    r.val = 8'(v);
    request_q.push_back(r);
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r.level = ($urandom_range(9) == 0) ? 4'd0 : 4'($urandom_range(15));
    r.dir = 4'($urandom_range(15));
    r.val = 8'($urandom_range(255));
    r.idx = 6'($urandom_range(63));
    if (pick < 55) begin
      r.op = sgw_pkg::OP_TICK;
    end else begin
      r.op = sgw_pkg::op_e'($urandom_range(3, 1));
      if ($urandom_range(99) < 85) begin
        case (r.op)
          sgw_pkg::OP_PERIOD: r.idx = 6'($urandom_range(15));
          sgw_pkg::OP_AMP:    r.idx = 6'($urandom_range(47));
          default:            r.idx = 6'($urandom_range(23));
        endcase
      end
      if (r.op == sgw_pkg::OP_PERIOD && $urandom_range(99) < 40) r.val = 8'($urandom_range(20));
    end
    return r;
  endfunction

  task automatic write_reg(int i, logic [7:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= sgw_pkg::CFG_IW'(i);
    cfg_data <= v;
    if (i < sgw_pkg::JOINTS) trim[i] = v;
    else if (i < 2 * sgw_pkg::JOINTS) lag[i - sgw_pkg::JOINTS] = v;
  endtask

  task automatic settle();
    wait (request_q.size() == 0 && !in_valid && pending_poses.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    phase_ctr = '0;
    for (int k = 0; k < 16; k++) period_tab[k] = '0;
    for (int k = 0; k < 48; k++) amp_tab[k] = '0;
    for (int k = 0; k < 24; k++) turn_tab[k] = '0;
    for (int j = 0; j < 3; j++) begin
      trim[j] = sgw_pkg::TRIM_RESET;
      lag[j] = sgw_pkg::LAG_RESET[j];
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_request(sgw_pkg::OP_TICK, 0, 7, 0, 0);
    push_request(sgw_pkg::OP_TICK, 1, 7, 0, 0);
    push_request(sgw_pkg::OP_PERIOD, 0, 0, 1, 255);
    push_request(sgw_pkg::OP_PERIOD, 0, 0, 2, 1);
    push_request(sgw_pkg::OP_PERIOD, 0, 0, 15, 7);
    push_request(sgw_pkg::OP_PERIOD, 0, 0, 16, 9);
    push_request(sgw_pkg::OP_AMP, 0, 0, 3, 255);
    push_request(sgw_pkg::OP_AMP, 0, 0, 4, 255);
    push_request(sgw_pkg::OP_AMP, 0, 0, 5, 255);
    push_request(sgw_pkg::OP_AMP, 0, 0, 47, 200);
    push_request(sgw_pkg::OP_AMP, 0, 0, 63, 255);
    push_request(sgw_pkg::OP_TURN, 0, 0, 0, 255);
    push_request(sgw_pkg::OP_TURN, 0, 0, 23, 100);
    push_request(sgw_pkg::OP_TURN, 0, 0, 24, 77);
    push_request(sgw_pkg::OP_TICK, 1, 0, 0, 0);
    push_request(sgw_pkg::OP_TICK, 1, 6, 0, 0);
    push_request(sgw_pkg::OP_TICK, 1, 7, 0, 0);
    push_request(sgw_pkg::OP_TICK, 1, 14, 0, 0);
    push_request(sgw_pkg::OP_TICK, 1, 15, 0, 0);
    push_request(sgw_pkg::OP_TICK, 15, 15, 0, 0);
    push_request(sgw_pkg::OP_TICK, 2, 10, 0, 0);
    push_request(sgw_pkg::OP_TICK, 3, 3, 0, 0);
    push_request(sgw_pkg::OP_TICK, 0, 0, 0, 0);
    repeat (270) request_q.push_back(random_request());
    settle();

    for (int ph = 1; ph <= 4; ph++) begin
      for (int i = 0; i < 2 * sgw_pkg::JOINTS; i++) begin
        case (ph)
          1: write_reg(i, 8'd0);
          2: write_reg(i, 8'd255);
          default: write_reg(i, 8'($urandom_range(255)));
        endcase
      end
      if (ph == 3) begin
        write_reg(6, 8'($urandom_range(255)));
        write_reg(7, 8'($urandom_range(255)));
      end
      @(posedge clk_i);
      cfg_we <= 1'b0;
      no_idle = (ph == 4);
      repeat (290) request_q.push_back(random_request());
      settle();
    end

    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
